[rtl/core/bad_pkg.sv]
// shared types and constants for the box average downscaler
// no dependencies
package bad_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 24;
  localparam int unsigned NumCh   = 4;

  localparam logic [1:0] CfgFactor   = 2'd0;
  localparam logic [1:0] CfgWidth    = 2'd1;
  localparam logic [1:0] CfgHeight   = 2'd2;
  localparam logic [1:0] CfgChannels = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;    // load input pixel into stage registers
    logic       active;     // pixel lies in a full block
    logic       first_col;  // first column of a block
    logic       close_col;  // last column of a block: touch row store
    logic       first_row;  // first row of a block
    logic       last_row;   // last row of a block: emit result
    logic       row_end;
    logic       frame_end;
  } bad_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;       // divider or store access in progress
    logic out_full;   // output register holds a result
  } bad_sts_t;

endpackage

[rtl/core/bad_ram.sv]
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module bad_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/bad_ctrl.sv]
// controller: raster position counters, block tracking and item sequencing
// depends on bad_pkg
module bad_ctrl #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxFactor = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      restart_i,
  input  logic [$clog2(MaxFactor+1)-1:0] factor_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  width_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  height_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  nbx_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  lim_x_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  lim_y_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  nby_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bad_pkg::bad_sts_t         sts_i,
  output bad_pkg::bad_cmd_t         cmd_o,
  output logic [$clog2(MaxWidth)-1:0] block_col_o
);

  localparam int unsigned PW = $clog2(MaxWidth+1);
  localparam int unsigned FW = $clog2(MaxFactor+1);
  localparam int unsigned BW = $clog2(MaxWidth);

  localparam logic StIdle = 1'b0;
  localparam logic StWork = 1'b1;

  logic          state_q, state_d;
  logic [PW-1:0] col_q, row_q, bcol_q, brow_q;
  logic [FW-1:0] ibc_q, ibr_q;
  logic          take;

  assign in_ready_o = (state_q == StIdle) && !sts_i.busy && !sts_i.out_full;
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.capture   = take;
    cmd_o.active    = (col_q < lim_x_i) && (row_q < lim_y_i);
    cmd_o.first_col = (ibc_q == '0);
    cmd_o.close_col = ({{(PW-FW){1'b0}}, ibc_q} + PW'(1) >= PW'(factor_i));
    cmd_o.first_row = (ibr_q == '0);
    cmd_o.last_row  = ({{(PW-FW){1'b0}}, ibr_q} + PW'(1) >= PW'(factor_i));
    cmd_o.row_end   = (bcol_q + PW'(1) == nbx_i);
    cmd_o.frame_end = cmd_o.row_end && (brow_q + PW'(1) == nby_i);
    state_d = state_q;
    case (state_q)
      StIdle: if (take) state_d = StWork;
      StWork: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign block_col_o = bcol_q[BW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q <= '0; row_q <= '0; bcol_q <= '0; brow_q <= '0;
      ibc_q <= '0; ibr_q <= '0;
    end else if (restart_i) begin
      state_q <= StIdle;
      col_q <= '0; row_q <= '0; bcol_q <= '0; brow_q <= '0;
      ibc_q <= '0; ibr_q <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        if (col_q + PW'(1) >= width_i) begin
          col_q <= '0; ibc_q <= '0; bcol_q <= '0;
          if (row_q + PW'(1) >= height_i) begin
            row_q <= '0; ibr_q <= '0; brow_q <= '0;
          end else begin
            row_q <= row_q + PW'(1);
            if (cmd_o.last_row) begin
              ibr_q <= '0; brow_q <= brow_q + PW'(1);
            end else begin
              ibr_q <= ibr_q + FW'(1);
            end
          end
        end else begin
          col_q <= col_q + PW'(1);
          if (cmd_o.close_col) begin
            ibc_q <= '0; bcol_q <= bcol_q + PW'(1);
          end else begin
            ibc_q <= ibc_q + FW'(1);
          end
        end
      end
    end
  end

endmodule

[rtl/core/bad_dp.sv]
// datapath: horizontal partials, column sum store, serial divider, output register
// depends on bad_pkg and bad_ram
module bad_dp #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxFactor = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      restart_i,
  input  bad_pkg::bad_cmd_t         cmd_i,
  input  logic [$clog2(MaxWidth)-1:0] block_col_i,
  input  logic [2:0]                nch_i,
  input  logic [$clog2(MaxFactor+1)-1:0] factor_i,
  input  logic [63:0]               pix_i,
  output bad_pkg::bad_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [63:0]               out_data_o,
  output logic [1:0]                out_user_o
);

  localparam int unsigned SW = bad_pkg::SumW;
  localparam int unsigned NC = bad_pkg::NumCh;
  localparam int unsigned BW = $clog2(MaxWidth);
  localparam int unsigned FW = $clog2(MaxFactor+1);
  localparam int unsigned DW = 2*FW;
  localparam int unsigned CntW = $clog2(SW+1);

  logic [SW-1:0] hp_q [NC];
  logic [SW-1:0] tot_q [NC];
  logic [SW-1:0] rdat [NC];
  logic [SW-1:0] quo_q [NC];
  logic [DW:0]   rem_q [NC];
  logic [DW-1:0] div_q;
  logic          rd_q, div_run_q;
  logic [CntW-1:0] cnt_q;
  logic          first_row_q, last_row_q, re_q, fe_q;
  logic [2:0]    nch_q;
  logic          out_full_q;
  logic [BW-1:0] bcol_q;
  logic [NC-1:0] we;
  logic [SW-1:0] sum [NC];

  assign sts_o.busy = rd_q || div_run_q;
  assign sts_o.out_full = out_full_q;
  assign out_valid_o = out_full_q;

  for (genvar c = 0; c < NC; c++) begin : g_ch
    logic [SW-1:0] s_ext;
    assign s_ext = {{(SW-16){1'b0}}, pix_i[16*c +: 16]};
    assign sum[c] = first_row_q ? hp_q[c] : hp_q[c] + rdat[c];
    assign we[c] = rd_q && !last_row_q;

    bad_ram #(.Width(SW), .Depth(MaxWidth)) u_ram (
      .clk_i, .we_i(we[c]), .waddr_i(bcol_q), .wdata_i(sum[c]),
      .raddr_i(block_col_i), .rdata_o(rdat[c])
    );

    always_ff @(posedge clk_i) begin
      if (cmd_i.capture && cmd_i.active && (3'(c) < nch_i)) begin
        hp_q[c] <= cmd_i.first_col ? s_ext : hp_q[c] + s_ext;
      end
      if (rd_q) begin
        tot_q[c] <= (3'(c) < nch_q) ? sum[c] : '0;
        quo_q[c] <= '0;
        rem_q[c] <= '0;
      end else if (div_run_q) begin
        // restoring division, one quotient bit per cycle
        logic [DW:0] r;
        r = {rem_q[c][DW-1:0], tot_q[c][SW-1]};
        tot_q[c] <= {tot_q[c][SW-2:0], 1'b0};
        if (r >= {1'b0, div_q}) begin
          rem_q[c] <= r - {1'b0, div_q};
          quo_q[c] <= {quo_q[c][SW-2:0], 1'b1};
        end else begin
          rem_q[c] <= r;
          quo_q[c] <= {quo_q[c][SW-2:0], 1'b0};
        end
      end
    end

    assign out_data_o[16*c +: 16] = (quo_q[c][SW-1:16] != '0) ? 16'hffff : quo_q[c][15:0];
  end

  assign out_user_o = {fe_q, re_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bcol_q <= block_col_i;
      first_row_q <= cmd_i.first_row;
      last_row_q <= cmd_i.last_row;
      re_q <= cmd_i.row_end;
      fe_q <= cmd_i.frame_end;
      nch_q <= nch_i;
      div_q <= DW'(factor_i) * DW'(factor_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; div_run_q <= 1'b0; cnt_q <= '0; out_full_q <= 1'b0;
    end else begin
      rd_q <= cmd_i.capture && cmd_i.active && cmd_i.close_col && !restart_i;
      if (rd_q && last_row_q) begin
        div_run_q <= 1'b1;
        cnt_q <= CntW'(SW);
      end else if (div_run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          div_run_q <= 1'b0;
          out_full_q <= 1'b1;
        end
      end
      if (out_full_q && out_ready_i) out_full_q <= 1'b0;
    end
  end

endmodule

[rtl/core/box_average_downscale.sv]
// top level of the box average downscaler: config registers, controller, datapath
// depends on bad_pkg, bad_ctrl, bad_dp, bad_ram
//
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tdata: sample_0..sample_3
// m_axis    out        m_axis_tvalid/tready      tdata: average_0..3, tuser: row_end, frame_end
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// a pixel is taken in idle and then passes the work state, also when it closes a block
// row (store read and write fit there); a block's last pixel also waits for the serial divider
// a result waits in the output register; no pixel is accepted while it waits
// reset and any config write restart the frame; the row store needs no clearing
// after reset or a config write the input is held off while the block counts are found
module box_average_downscale #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_FACTOR   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sample_0, sample_1, sample_2, sample_3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // average_0, average_1, average_2, average_3
  output logic [1:0]  m_axis_tuser,  // row_end, frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned PW = $clog2(MAX_WIDTH+1);
  localparam int unsigned FW = $clog2(MAX_FACTOR+1);

  logic [4:0]  fac_q;
  logic [12:0] wid_q, hgt_q;
  logic [2:0]  nch_q;
  logic        wr;
  logic [FW-1:0] f;
  logic [PW-1:0] w, h, nbx, nby, limx, limy;
  logic [2:0]  nch;
  bad_pkg::bad_cmd_t cmd;
  bad_pkg::bad_sts_t sts;
  logic [$clog2(MAX_WIDTH)-1:0] bcol;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fac_q <= 5'd1; wid_q <= 13'd640; hgt_q <= 13'd480; nch_q <= 3'd3;
    end else if (wr) begin
      case (cfg_index_i)
        bad_pkg::CfgFactor:   fac_q <= cfg_data_i[4:0];
        bad_pkg::CfgWidth:    wid_q <= cfg_data_i;
        bad_pkg::CfgHeight:   hgt_q <= cfg_data_i;
        bad_pkg::CfgChannels: nch_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamped settings, static between writes; block counts settle once counting ends
  logic [PW-1:0] nbx_q, nby_q;
  always_comb begin
    f = (fac_q == 0) ? FW'(1) : (32'(fac_q) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(fac_q);
    w = (wid_q == 0) ? PW'(1) : (32'(wid_q) > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(wid_q);
    h = (hgt_q == 0) ? PW'(1) : (32'(hgt_q) > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(hgt_q);
    nch = (nch_q == 0) ? 3'd1 :
          (32'(nch_q) > bad_pkg::NumCh) ? 3'(bad_pkg::NumCh) : nch_q;
  end

  // block counts by repeated addition of the factor after reset and after each write
  logic [PW-1:0] rx_q, ry_q;
  logic          cnt_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_run_q <= 1'b1; rx_q <= '0; ry_q <= '0; nbx_q <= '0; nby_q <= '0;
    end else if (wr) begin
      cnt_run_q <= 1'b1; rx_q <= '0; ry_q <= '0; nbx_q <= '0; nby_q <= '0;
    end else if (cnt_run_q) begin
      if (rx_q + PW'(f) <= w) begin
        rx_q <= rx_q + PW'(f); nbx_q <= nbx_q + PW'(1);
      end
      if (ry_q + PW'(f) <= h) begin
        ry_q <= ry_q + PW'(f); nby_q <= nby_q + PW'(1);
      end
      if (rx_q + PW'(f) > w && ry_q + PW'(f) > h) cnt_run_q <= 1'b0;
    end
  end
  assign nbx = nbx_q;
  assign nby = nby_q;
  assign limx = rx_q;
  assign limy = ry_q;

  logic in_rdy;
  assign s_axis_tready = in_rdy && !cnt_run_q;

  bad_ctrl #(.MaxWidth(MAX_WIDTH), .MaxFactor(MAX_FACTOR)) u_ctrl (
    .clk_i, .rst_ni, .restart_i(wr), .factor_i(f), .width_i(w), .height_i(h),
    .nbx_i(nbx), .lim_x_i(limx), .lim_y_i(limy), .nby_i(nby),
    .in_valid_i(s_axis_tvalid && !cnt_run_q), .in_ready_o(in_rdy),
    .sts_i(sts), .cmd_o(cmd), .block_col_o(bcol)
  );

  bad_dp #(.MaxWidth(MAX_WIDTH), .MaxFactor(MAX_FACTOR)) u_dp (
    .clk_i, .rst_ni, .restart_i(wr), .cmd_i(cmd), .block_col_i(bcol),
    .nch_i(nch), .factor_i(f), .pix_i(s_axis_tdata), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_user_o(m_axis_tuser)
  );

endmodule

[verif/tb_box_average_downscale.sv]
// self-checking testbench for box_average_downscale: pixel frames in, block averages out
// depends on bad_pkg and the box_average_downscale rtl
module tb_box_average_downscale;

  typedef struct packed {
    logic [15:0] avg0, avg1, avg2, avg3;
    logic        row_end;
    logic        frame_end;
  } block_avg_t;

  // tracks the downscaler state and queues the expected block averages
  class avg_scoreboard;
    int unsigned factor, width, height, chans;
    logic [23:0] col_sum [0:4095][0:3];
    logic [23:0] row_part [0:3];
    int unsigned col, row, sub_col, sub_row;
    block_avg_t  pending [$];
    int unsigned errors, results;

    function new();
      factor = 1; width = 640; height = 480; chans = 3;
      restart();
    endfunction

    function void restart();
      col = 0; row = 0; sub_col = 0; sub_row = 0;
      for (int i = 0; i < 4; i++) row_part[i] = '0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        bad_pkg::CfgFactor:   factor = val[4:0];
        bad_pkg::CfgWidth:    width  = val;
        bad_pkg::CfgHeight:   height = val;
        bad_pkg::CfgChannels: chans  = val[2:0];
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [63:0] px);
      int unsigned f, w, h, n, nbx, nby, bc, total;
      logic [15:0] s;
      logic last_row;
      block_avg_t r;
      f = clip(factor, 16); w = clip(width, 4096);
      h = clip(height, 4096); n = clip(chans, 4);
      nbx = w / f; nby = h / f;
      if (col < nbx * f && row < nby * f) begin
        for (int c = 0; c < n; c++) begin
          s = px[16*c +: 16];
          row_part[c] = (sub_col == 0) ? 24'(s) : 24'(row_part[c] + s);
        end
        if (sub_col + 1 >= f) begin
          bc = (col / f) % 4096;
          last_row = (sub_row + 1 >= f);
          r = '0;
          for (int c = 0; c < 4; c++) begin
            total = 0;
            if (c < n) begin
              total = row_part[c];
              if (sub_row != 0) total = (total + col_sum[bc][c]) & 24'hffffff;
              if (!last_row) col_sum[bc][c] = 24'(total);
            end
            total = total / (f * f);
            if (total > 65535) total = 65535;
            case (c)
              0: r.avg0 = 16'(total);
              1: r.avg1 = 16'(total);
              2: r.avg2 = 16'(total);
              default: r.avg3 = 16'(total);
            endcase
          end
          if (last_row) begin
            r.row_end = (bc + 1 == nbx);
            r.frame_end = r.row_end && (row / f + 1 == nby);
            pending.push_back(r);
          end
        end
      end
      sub_col = (sub_col + 1 >= f) ? 0 : sub_col + 1;
      col++;
      if (col >= w) begin
        col = 0; sub_col = 0;
        sub_row = (sub_row + 1 >= f) ? 0 : sub_row + 1;
        row++;
        if (row >= h) begin
          row = 0; sub_row = 0;
        end
      end
    endfunction

    function void check_result(block_avg_t got);
      block_avg_t want;
      results++;
      if (pending.size() == 0) begin
        $error("result with none expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.avg0 !== want.avg0) begin
        $error("average_0 exp %0d got %0d", want.avg0, got.avg0); errors++;
      end
      if (got.avg1 !== want.avg1) begin
        $error("average_1 exp %0d got %0d", want.avg1, got.avg1); errors++;
      end
      if (got.avg2 !== want.avg2) begin
        $error("average_2 exp %0d got %0d", want.avg2, got.avg2); errors++;
      end
      if (got.avg3 !== want.avg3) begin
        $error("average_3 exp %0d got %0d", want.avg3, got.avg3); errors++;
      end
      if (got.row_end !== want.row_end) begin
        $error("row_end exp %0d got %0d", want.row_end, got.row_end); errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end exp %0d got %0d", want.frame_end, got.frame_end); errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  box_average_downscale uut (.*);

  avg_scoreboard board = new();
  bit quiet_tail;      // no idling near the end
  int hold_off;        // long receiver stall, in cycles
  int unsigned pixels_sent;
  longint unsigned cycles;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int gap;
    m_axis_tready = 0;
    gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                            m_axis_tdata[63:48], m_axis_tuser[0], m_axis_tuser[1]});
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        // this cycle idles, gap counts the rest of the burst
        gap = $urandom_range(1, 3) - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  task automatic send_pixel(logic [63:0] px);
    if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pixel(px);
    pixels_sent++;
  endtask

  function automatic logic [63:0] rand_pixel();
    logic [63:0] p;
    for (int c = 0; c < 4; c++)
      case ($urandom_range(0, 5))
        0: p[16*c +: 16] = 16'h0000;
        1: p[16*c +: 16] = 16'hffff;
        default: p[16*c +: 16] = 16'($urandom);
      endcase
    return p;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  task automatic set_shape(int f, int w, int h, int n);
    write_reg(bad_pkg::CfgFactor, 13'(f));
    write_reg(bad_pkg::CfgWidth, 13'(w));
    write_reg(bad_pkg::CfgHeight, 13'(h));
    write_reg(bad_pkg::CfgChannels, 13'(n));
  endtask

  // sends whole frames so every column store entry is written before read
  task automatic send_frames(int count);
    int unsigned w, h;
    w = board.clip(board.width, 4096);
    h = board.clip(board.height, 4096);
    repeat (count)
      for (int i = 0; i < w * h; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    int f, w, h;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    cfg_valid_i = 0; cfg_index_i = bad_pkg::CfgFactor; cfg_data_i = '0;
    quiet_tail = 0; hold_off = 0; cycles = 0; pixels_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extreme samples, one channel and all channels, factor 1 and 16
    set_shape(1, 4, 2, 4);
    send_pixel('0);
    send_pixel('1);
    send_pixel(64'h0001_8000_7fff_ffff);
    for (int i = 0; i < 5; i++) send_pixel(rand_pixel());
    set_shape(2, 5, 3, 1);          // partial column and row dropped
    for (int i = 0; i < 15; i++) send_pixel('1);
    set_shape(16, 16, 16, 2);        // largest block, all-ones sums
    for (int i = 0; i < 256; i++) send_pixel('1);
    set_shape(4, 3, 3, 3);           // image smaller than a block
    for (int i = 0; i < 9; i++) send_pixel(rand_pixel());
    set_shape(0, 0, 0, 0);           // zero acts as one
    send_frames(2);
    set_shape(31, 4097, 2, 7);       // above-range values clamp
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
    write_reg(bad_pkg::CfgHeight, 32);
    set_shape(2, 4, 4, 3);
    for (int i = 0; i < 5; i++) send_pixel(rand_pixel());
    write_reg(bad_pkg::CfgChannels, 3);  // mid-frame restart
    send_frames(1);

    // long receiver hold-off while pixels keep coming
    set_shape(1, 8, 8, 4);
    hold_off = 200;
    send_frames(1);

    // random shapes, mostly small
    while (pixels_sent < 760) begin
      f = $urandom_range(1, 4);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_shape(f, w, h, $urandom_range(1, 4));
      send_frames($urandom_range(1, 2));
      if (pixels_sent > 650) quiet_tail = 1;
    end
    quiet_tail = 1;
    set_shape(3, 9, 6, 4);
    send_frames(2);

    drain();
    $display("sent %0d pixels over many frame shapes, checked %0d block averages",
             pixels_sent, board.results);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
